>>> design/pfcp_pkg.sv
// ----------------------------------------------------------------------------
// Pauli frame propagator package
// Shared widths, constants, codes and types for the Clifford frame propagator.
// ----------------------------------------------------------------------------
package pfcp_pkg;

   // Frame size and weight format.
   localparam int NUM_QUBITS       = 64;
   localparam int WEIGHT_FRAC_BITS = 30;

   // Field widths fixed by the request and response formats.
   localparam int ACTION_W = 3;
   localparam int QUBIT_W  = 6;
   localparam int RATE_W   = 16;
   localparam int MASK_W   = 64;
   localparam int WEIGHT_W = 32;

   // Weight magnitude holds values up to one, so one bit above the fraction.
   localparam int MAG_W    = WEIGHT_FRAC_BITS + 1;
   localparam int FACTOR_W = RATE_W + 1;
   localparam int PROD_W   = MAG_W + FACTOR_W;

   localparam logic [MAG_W-1:0]    ONE_MAG       = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
   localparam logic [FACTOR_W-1:0] FACTOR_FULL   = {1'b1, {RATE_W{1'b0}}};
   localparam logic [QUBIT_W:0]    QUBIT_COUNT   = (QUBIT_W + 1)'(NUM_QUBITS);
   localparam logic [MASK_W-1:0]   QUBIT_MASK    = {MASK_W{1'b1}} >> (MASK_W - NUM_QUBITS);
   localparam logic [MASK_W-1:0]   BIT_ONE       = MASK_W'(1);

   // Gate codes carried in the action field.
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD     = 3'd0,
      ACT_HADAMARD = 3'd1,
      ACT_PHASE    = 3'd2,
      ACT_CNOT     = 3'd3,
      ACT_DEPOL    = 3'd4
   } action_type;

   // One gate request as held in the input register.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [QUBIT_W-1:0]  qubit_a;
      logic [QUBIT_W-1:0]  qubit_b;
      logic [RATE_W-1:0]   noise_rate;
      logic [MASK_W-1:0]   load_x_mask;
      logic [MASK_W-1:0]   load_z_mask;
   } gate_item_type;

   // Pauli frame with the weight kept as sign and magnitude.
   typedef struct packed {
      logic [MASK_W-1:0] x_bits;
      logic [MASK_W-1:0] z_bits;
      logic              neg;
      logic [MAG_W-1:0]  mag;
   } frame_type;

   // Converts a sign and magnitude weight to two's complement.
   function automatic logic signed [WEIGHT_W-1:0] weight_to_twos(
      input logic             neg,
      input logic [MAG_W-1:0] mag
   );
      logic signed [WEIGHT_W-1:0] wide;
      wide = WEIGHT_W'(mag);
      return neg ? -wide : wide;
   endfunction

endpackage

>>> design/pfcp_if.sv
// ----------------------------------------------------------------------------
// Pauli frame propagator channels
// Valid/ready channels for gate requests and frame responses.
// ----------------------------------------------------------------------------
interface pfcp_req_if;
   import pfcp_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [QUBIT_W-1:0]  qubit_a;
   logic [QUBIT_W-1:0]  qubit_b;
   logic [RATE_W-1:0]   noise_rate;
   logic [MASK_W-1:0]   load_x_mask;
   logic [MASK_W-1:0]   load_z_mask;

   modport source (
      output valid, action, qubit_a, qubit_b, noise_rate, load_x_mask, load_z_mask,
      input  ready
   );
   modport sink (
      input  valid, action, qubit_a, qubit_b, noise_rate, load_x_mask, load_z_mask,
      output ready
   );
endinterface

interface pfcp_rsp_if;
   import pfcp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MASK_W-1:0]          x_mask;
   logic [MASK_W-1:0]          z_mask;
   logic signed [WEIGHT_W-1:0] path_weight;
   logic                       no_x_flag;

   modport source (
      output valid, x_mask, z_mask, path_weight, no_x_flag,
      input  ready
   );
   modport sink (
      input  valid, x_mask, z_mask, path_weight, no_x_flag,
      output ready
   );
endinterface

>>> design/pauli_frame_clifford_propagator.sv
// ----------------------------------------------------------------------------
// Pauli frame Clifford propagator
// Propagates one Pauli string and its signed weight through a gate stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries gate requests (load, Hadamard, phase S, CNOT,
//   depolarizing); rsp_chan returns one response per request with the X and
//   Z masks, the Q1.30 path weight and a flag set when the X mask is zero.
//   A request is registered, then updates the frame and the response
//   register once the response register is free or being drained. One
//   request is accepted in every cycle while rsp_chan.ready stays high; the
//   rate is set by the frame update loop (bit picks, toggles and one
//   31 by 17 bit multiply for the depolarizing scale).
//   Reset clears both masks, sets the weight to one and empties the request
//   and response registers. When the receiver holds rsp_chan.ready low, the
//   response register keeps its response and one more request is held in
//   the request register; after that req_chan.ready drops until the
//   response is taken.
// ----------------------------------------------------------------------------
module pauli_frame_clifford_propagator (
   input  logic      clock,
   input  logic      reset,
   pfcp_req_if.sink  req_chan,
   pfcp_rsp_if.source rsp_chan
);
   import pfcp_pkg::*;

   logic          item_valid;
   gate_item_type item;
   logic          advance;
   frame_type     frame_next;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [MASK_W-1:0] x_mask_ff;
   logic [MASK_W-1:0] z_mask_ff;
   logic              neg_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              no_x_ff;

   // The held request moves on when the response register is free or draining.
   assign advance = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   pfcp_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pfcp_frame_core u_frame_core (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .item       (item),
      .frame_next (frame_next)
   );

   // Response register valid flag.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload captures the updated frame.
   always_ff @(posedge clock) begin
      if (advance) begin
         x_mask_ff <= frame_next.x_bits;
         z_mask_ff <= frame_next.z_bits;
         neg_ff    <= frame_next.neg;
         mag_ff    <= frame_next.mag;
         no_x_ff   <= (frame_next.x_bits == '0);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.x_mask      = x_mask_ff;
   assign rsp_chan.z_mask      = z_mask_ff;
   assign rsp_chan.path_weight = weight_to_twos(neg_ff, mag_ff);
   assign rsp_chan.no_x_flag   = no_x_ff;

endmodule

>>> design/pfcp_req_stage.sv
// ----------------------------------------------------------------------------
// Pauli frame propagator request stage
// Registers one gate request and holds it until the frame update takes it.
// ----------------------------------------------------------------------------
module pfcp_req_stage (
   input  logic                   clock,
   input  logic                   reset,
   pfcp_req_if.sink               req_chan,
   input  logic                   advance,
   output logic                   item_valid,
   output pfcp_pkg::gate_item_type item
);
   import pfcp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   gate_item_type item_ff;
   logic          accept;

   // The register can take a new request when empty or being drained.
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action      <= req_chan.action;
         item_ff.qubit_a     <= req_chan.qubit_a;
         item_ff.qubit_b     <= req_chan.qubit_b;
         item_ff.noise_rate  <= req_chan.noise_rate;
         item_ff.load_x_mask <= req_chan.load_x_mask;
         item_ff.load_z_mask <= req_chan.load_z_mask;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/pfcp_frame_core.sv
// ----------------------------------------------------------------------------
// Pauli frame propagator core
// Holds the Pauli frame and computes its next value for one gate request.
// ----------------------------------------------------------------------------
module pfcp_frame_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  pfcp_pkg::gate_item_type item,
   output pfcp_pkg::frame_type     frame_next
);
   import pfcp_pkg::*;

   frame_type         frame_ff;
   frame_type         frame_in;
   logic              a_ok;
   logic              b_ok;
   logic              xa;
   logic              za;
   logic              xb;
   logic              zb;
   logic [MASK_W-1:0] mask_a;
   logic [MASK_W-1:0] mask_b;
   logic [FACTOR_W-1:0] factor;
   logic [PROD_W-1:0]   product;
   logic [MAG_W-1:0]    scaled;

   // Qubit range checks and bit picks at both addressed qubits.
   assign a_ok   = {1'b0, item.qubit_a} < QUBIT_COUNT;
   assign b_ok   = {1'b0, item.qubit_b} < QUBIT_COUNT;
   assign xa     = frame_ff.x_bits[item.qubit_a];
   assign za     = frame_ff.z_bits[item.qubit_a];
   assign xb     = frame_ff.x_bits[item.qubit_b];
   assign zb     = frame_ff.z_bits[item.qubit_b];
   assign mask_a = BIT_ONE << item.qubit_a;
   assign mask_b = BIT_ONE << item.qubit_b;

   // Depolarizing scale: magnitude times (1 - theta), truncated.
   assign factor  = FACTOR_FULL - FACTOR_W'(item.noise_rate);
   assign product = PROD_W'(frame_ff.mag) * PROD_W'(factor);
   assign scaled  = product[RATE_W +: MAG_W];

   // Gate decode and frame update.
   always_comb begin
      frame_in = frame_ff;
      unique case (action_type'(item.action))
         ACT_LOAD: begin
            frame_in.x_bits = item.load_x_mask & QUBIT_MASK;
            frame_in.z_bits = item.load_z_mask & QUBIT_MASK;
            frame_in.neg    = 1'b0;
            frame_in.mag    = ONE_MAG;
         end
         ACT_HADAMARD: begin
            if (a_ok) begin
               frame_in.neg = frame_ff.neg ^ (xa && za);
               if (xa != za) begin
                  frame_in.x_bits = frame_ff.x_bits ^ mask_a;
                  frame_in.z_bits = frame_ff.z_bits ^ mask_a;
               end
            end
         end
         ACT_PHASE: begin
            if (a_ok) begin
               frame_in.neg = frame_ff.neg ^ (xa && !za);
               if (xa) begin
                  frame_in.z_bits = frame_ff.z_bits ^ mask_a;
               end
            end
         end
         ACT_CNOT: begin
            if (a_ok && b_ok && (item.qubit_a != item.qubit_b)) begin
               frame_in.neg = frame_ff.neg ^ (xa && zb && !(xb ^ za));
               if (xa) begin
                  frame_in.x_bits = frame_ff.x_bits ^ mask_b;
               end
               if (zb) begin
                  frame_in.z_bits = frame_ff.z_bits ^ mask_a;
               end
            end
         end
         ACT_DEPOL: begin
            if (a_ok && (xa || za)) begin
               frame_in.mag = scaled;
            end
         end
         default: begin
            frame_in = frame_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff.x_bits <= '0;
         frame_ff.z_bits <= '0;
         frame_ff.neg    <= 1'b0;
         frame_ff.mag    <= ONE_MAG;
      end else if (update) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_next = frame_in;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the Pauli frame Clifford propagator
// Drives gate requests (load, Hadamard, phase S, CNOT, depolarizing and the
// unused codes) through the request channel and compares every response with
// a frame model kept in the testbench or a frame typed in a short directed
// table. The directed requests come first, then randomized gate streams. Both
// channels idle in random bursts, and the run ends with a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
   import pfcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Action codes the block leaves without effect.
   localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

   // Weight and mask constants used by the directed table.
   localparam logic signed [WEIGHT_W-1:0] ONE_W     = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
   localparam logic signed [WEIGHT_W-1:0] NEG_ONE_W = -ONE_W;
   localparam logic [MASK_W-1:0] ALL_ONES  = '1;
   localparam logic [MASK_W-1:0] NO_BITS   = '0;
   localparam logic [MASK_W-1:0] ODD_BITS  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [MASK_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;

   // Run shape.
   localparam int RANDOM_ITEMS = 750;
   localparam int QUIET_ITEMS  = 120;
   localparam int PAUSE_AT     = 375;
   localparam int DRAIN_CYCLES = 10;

   // One response as seen on the response channel.
   typedef struct packed {
      logic [MASK_W-1:0]          x_mask;
      logic [MASK_W-1:0]          z_mask;
      logic signed [WEIGHT_W-1:0] path_weight;
      logic                       no_x_flag;
   } frame_view_type;

   // One row of the directed table; the expected frame is used only when typed.
   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic [QUBIT_W-1:0]         qubit_a;
      logic [QUBIT_W-1:0]         qubit_b;
      logic [RATE_W-1:0]          noise_rate;
      logic [MASK_W-1:0]          load_x_mask;
      logic [MASK_W-1:0]          load_z_mask;
      logic                       typed;
      logic [MASK_W-1:0]          want_x;
      logic [MASK_W-1:0]          want_z;
      logic signed [WEIGHT_W-1:0] want_w;
      logic                       want_flag;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   pfcp_req_if req_chan ();
   pfcp_rsp_if rsp_chan ();

   pauli_frame_clifford_propagator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Model of the Pauli frame held by the block.
   logic [MASK_W-1:0]          model_x;
   logic [MASK_W-1:0]          model_z;
   logic signed [WEIGHT_W-1:0] model_w;

   frame_view_type frames_due[$];
   dir_row_type    directed_rows[$];

   int  mismatch_count = 0;
   int  frames_checked = 0;
   int  diagonal_seen  = 0;
   int  negative_seen  = 0;
   int  zero_w_seen    = 0;
   int  gates_by_code[8];
   bit  gaps_on        = 1'b1;
   bit  quiet_phase    = 1'b0;

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one gate to the model frame and returns the response it implies.
   function automatic frame_view_type propagate_frame(gate_item_type g);
      frame_view_type       view;
      logic                 a_ok, b_ok, xa, za, xb, zb, neg;
      logic [WEIGHT_W-1:0]  mag;
      logic [RATE_W:0]      factor;
      logic [63:0]          prod;
      a_ok = int'(g.qubit_a) < NUM_QUBITS;
      b_ok = int'(g.qubit_b) < NUM_QUBITS;
      xa   = model_x[g.qubit_a];
      za   = model_z[g.qubit_a];
      xb   = model_x[g.qubit_b];
      zb   = model_z[g.qubit_b];
      case (g.action)
         ACT_LOAD: begin
            model_x = g.load_x_mask & QUBIT_MASK;
            model_z = g.load_z_mask & QUBIT_MASK;
            model_w = ONE_W;
         end
         ACT_HADAMARD: begin
            // Y picks up a sign; X and Z trade places.
            if (a_ok) begin
               if (xa && za) model_w = -model_w;
               model_x[g.qubit_a] = za;
               model_z[g.qubit_a] = xa;
            end
         end
         ACT_PHASE: begin
            // X turns into Y with a sign flip; Y turns into X.
            if (a_ok) begin
               if (xa && !za) model_w = -model_w;
               if (xa) model_z[g.qubit_a] = ~za;
            end
         end
         ACT_CNOT: begin
            // All four bits were captured above, before any toggle.
            if (a_ok && b_ok && g.qubit_a != g.qubit_b) begin
               if (xa && zb && !(xb ^ za)) model_w = -model_w;
               if (xa) model_x[g.qubit_b] = ~xb;
               if (zb) model_z[g.qubit_a] = ~za;
            end
         end
         ACT_DEPOL: begin
            // Scale the magnitude by (1 - theta), truncating toward zero.
            if (a_ok && (xa || za)) begin
               neg    = model_w[WEIGHT_W-1];
               mag    = neg ? -model_w : model_w;
               factor = {1'b1, {RATE_W{1'b0}}} - {1'b0, g.noise_rate};
               prod   = (64'(mag) * 64'(factor)) >> RATE_W;
               model_w = neg ? -prod[WEIGHT_W-1:0] : prod[WEIGHT_W-1:0];
            end
         end
         default: ;
      endcase
      view.x_mask      = model_x;
      view.z_mask      = model_z;
      view.path_weight = model_w;
      view.no_x_flag   = (model_x == '0);
      return view;
   endfunction

   // Builds one random gate; every field is randomized, the action is weighted.
   function automatic gate_item_type random_gate();
      gate_item_type g;
      int            pick;
      g.qubit_a     = QUBIT_W'($urandom_range(0, 63));
      g.qubit_b     = QUBIT_W'($urandom_range(0, 63));
      g.noise_rate  = RATE_W'($urandom_range(0, 65535));
      g.load_x_mask = {$urandom(), $urandom()};
      g.load_z_mask = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         g.action = ACT_LOAD;
         // Vary the X density so the diagonal flag is reached.
         case ($urandom_range(0, 3))
            1: g.load_x_mask = '0;
            2: g.load_x_mask &= {$urandom(), $urandom()} & {$urandom(), $urandom()};
            3: g.load_x_mask = BIT_ONE << $urandom_range(0, 63);
            default: ;
         endcase
      end else if (pick < 28) begin
         g.action = ACT_HADAMARD;
      end else if (pick < 50) begin
         g.action = ACT_PHASE;
      end else if (pick < 74) begin
         g.action = ACT_CNOT;
         if ($urandom_range(0, 15) == 0) g.qubit_b = g.qubit_a;
      end else if (pick < 94) begin
         g.action = ACT_DEPOL;
         // Mostly weak noise so the weight survives between loads.
         case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: g.noise_rate = RATE_W'($urandom_range(0, 1023));
            6: g.noise_rate = '1;
            7: g.noise_rate = '0;
            default: ;
         endcase
      end else begin
         g.action = ACT_SPARE_FIRST + ACTION_W'($urandom_range(0, 2));
      end
      return g;
   endfunction

   // Prints one failure line and counts it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Sends one request, waits for it to be taken and queues its expected frame.
   // Called just after a rising edge; returns just after the accepting edge.
   task automatic issue_gate(gate_item_type g, bit typed, frame_view_type typed_want);
      frame_view_type want;
      bit             taken;
      if (gaps_on && !quiet_phase && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= g.action;
      req_chan.qubit_a     <= g.qubit_a;
      req_chan.qubit_b     <= g.qubit_b;
      req_chan.noise_rate  <= g.noise_rate;
      req_chan.load_x_mask <= g.load_x_mask;
      req_chan.load_z_mask <= g.load_z_mask;
      // Sample the handshake mid-cycle, where every signal has settled.
      do begin
         @(negedge clock);
         taken = (req_chan.ready === 1'b1);
         @(posedge clock);
      end while (!taken);
      want = propagate_frame(g);
      if (typed) want = typed_want;
      frames_due.push_back(want);
      gates_by_code[g.action]++;
   endtask

   // Response checker: compares each taken response with the oldest expectation.
   always @(negedge clock) begin
      frame_view_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (frames_due.size() == 0) begin
            report_mismatch("response with no request pending", rsp_chan.x_mask, '0);
         end else begin
            want = frames_due.pop_front();
            frames_checked++;
            if (rsp_chan.x_mask !== want.x_mask)
               report_mismatch("x_mask", rsp_chan.x_mask, want.x_mask);
            if (rsp_chan.z_mask !== want.z_mask)
               report_mismatch("z_mask", rsp_chan.z_mask, want.z_mask);
            if (rsp_chan.path_weight !== want.path_weight)
               report_mismatch("path_weight", 64'(rsp_chan.path_weight),
                               64'(want.path_weight));
            if (rsp_chan.no_x_flag !== want.no_x_flag)
               report_mismatch("no_x_flag", 64'(rsp_chan.no_x_flag), 64'(want.no_x_flag));
            if (want.no_x_flag) diagonal_seen++;
            if (want.path_weight < 0) negative_seen++;
            if (want.path_weight == 0) zero_w_seen++;
         end
      end
   end

   // Response side: ready drops in random bursts, except in the final stretch.
   initial begin
      int stall_left;
      int mode_left;
      bit stalls_on;
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      mode_left  = 0;
      stalls_on  = 1'b1;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stalls_on = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(50, 200);
         end else begin
            mode_left--;
         end
         if (quiet_phase) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Request side: reset, directed table, random stream, drain and verdict.
   initial begin
      gate_item_type  g;
      frame_view_type typed_want;
      int             spare_count;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_LOAD;
      req_chan.qubit_a     <= '0;
      req_chan.qubit_b     <= '0;
      req_chan.noise_rate  <= '0;
      req_chan.load_x_mask <= '0;
      req_chan.load_z_mask <= '0;
      model_x = '0;
      model_z = '0;
      model_w = ONE_W;

      // Directed table: action, qubits, rate, load masks, typed, expected frame.
      directed_rows.push_back(dir_row_type'{ACT_SPARE_FIRST, 6'd0, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b1, NO_BITS, NO_BITS, ONE_W, 1'b1});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd0, 6'd0, 16'hFFFF,
         NO_BITS, NO_BITS, 1'b1, NO_BITS, NO_BITS, ONE_W, 1'b1});
      directed_rows.push_back(dir_row_type'{ACT_HADAMARD, 6'd63, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_SPARE_LAST, 6'd63, 6'd63, 16'hFFFF,
         ALL_ONES, ALL_ONES, 1'b1, NO_BITS, NO_BITS, ONE_W, 1'b1});
      directed_rows.push_back(dir_row_type'{ACT_LOAD, 6'd0, 6'd0, 16'h0000,
         ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, ONE_W, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_HADAMARD, 6'd63, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b1, ALL_ONES, ALL_ONES, NEG_ONE_W, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_PHASE, 6'd0, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_PHASE, 6'd0, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_CNOT, 6'd0, 6'd63, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      // CNOT with control equal to target leaves the frame alone.
      directed_rows.push_back(dir_row_type'{ACT_CNOT, 6'd5, 6'd5, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd1, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd2, 6'd0, 16'hFFFF,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_LOAD, 6'd0, 6'd0, 16'h0000,
         NO_BITS, ALL_ONES, 1'b1, NO_BITS, ALL_ONES, ONE_W, 1'b1});
      directed_rows.push_back(dir_row_type'{ACT_HADAMARD, 6'd10, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_PHASE, 6'd10, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_LOAD, 6'd0, 6'd0, 16'h0000,
         ODD_BITS, EVEN_BITS, 1'b1, ODD_BITS, EVEN_BITS, ONE_W, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_CNOT, 6'd63, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      // Two strongest depolarizing steps drive the weight down to zero.
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd63, 6'd0, 16'hFFFF,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd63, 6'd0, 16'hFFFF,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      // Negating a zero weight on Y must keep it zero.
      directed_rows.push_back(dir_row_type'{ACT_HADAMARD, 6'd0, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_LOAD, 6'd0, 6'd0, 16'h0000,
         ALL_ONES, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_CNOT, 6'd63, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd0, 6'd0, 16'h8001,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});
      directed_rows.push_back(dir_row_type'{ACT_LOAD, 6'd0, 6'd0, 16'h0000,
         NO_BITS, NO_BITS, 1'b1, NO_BITS, NO_BITS, ONE_W, 1'b1});
      directed_rows.push_back(dir_row_type'{ACT_DEPOL, 6'd40, 6'd0, 16'h1234,
         NO_BITS, NO_BITS, 1'b0, NO_BITS, NO_BITS, '0, 1'b0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (directed_rows[i]) begin
         g.action      = directed_rows[i].action;
         g.qubit_a     = directed_rows[i].qubit_a;
         g.qubit_b     = directed_rows[i].qubit_b;
         g.noise_rate  = directed_rows[i].noise_rate;
         g.load_x_mask = directed_rows[i].load_x_mask;
         g.load_z_mask = directed_rows[i].load_z_mask;
         typed_want.x_mask      = directed_rows[i].want_x;
         typed_want.z_mask      = directed_rows[i].want_z;
         typed_want.path_weight = directed_rows[i].want_w;
         typed_want.no_x_flag   = directed_rows[i].want_flag;
         issue_gate(g, directed_rows[i].typed, typed_want);
      end

      // Random part; idling is switched on and off in stretches.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
         if (n == PAUSE_AT) begin
            // Let the block run completely dry once.
            req_chan.valid <= 1'b0;
            while (frames_due.size() != 0) @(posedge clock);
         end
         issue_gate(random_gate(), 1'b0, '0);
      end
      req_chan.valid <= 1'b0;

      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      spare_count = 0;
      for (int c = int'(ACT_SPARE_FIRST); c <= int'(ACT_SPARE_LAST); c++) begin
         spare_count += gates_by_code[c];
      end
      $display("Covered %0d requests: %0d loads, %0d H, %0d S, %0d CNOT, %0d noise, %0d unused",
               frames_checked, gates_by_code[ACT_LOAD], gates_by_code[ACT_HADAMARD],
               gates_by_code[ACT_PHASE], gates_by_code[ACT_CNOT], gates_by_code[ACT_DEPOL],
               spare_count);
      $display("Frames seen: %0d diagonal, %0d negative weight, %0d zero weight",
               diagonal_seen, negative_seen, zero_w_seen);
      if (mismatch_count == 0 && frames_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("Timeout with %0d responses outstanding", frames_due.size());
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
